// ----- hw/rtl/bsft_pkg.sv -----
package bsft_pkg;

  localparam logic [7:0]  FlagOctet = 8'h7E;
  localparam logic [7:0]  EscOctet  = 8'h7D;
  localparam logic [7:0]  EscFlip   = 8'h20;
  localparam logic [15:0] CrcStart  = 16'hFFFF;

  // Job queue between front and back (depth kept a power of two).
  localparam int unsigned QDepth = 2;
  localparam int unsigned QPtrW  = $clog2(QDepth);
  localparam int unsigned QCntW  = $clog2(QDepth + 1);

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_req_t;

  typedef struct packed {
    logic [7:0] line_byte;
    logic       run_last;
    logic       frame_end;
  } out_req_t;

  // One classified payload byte, ready for the line sequencer.
  typedef struct packed {
    logic [7:0]  data_byte;
    logic        last_byte;
    logic        open_frame;
    logic [15:0] crc;
  } job_t;

  typedef enum logic [3:0] {
    PH_HEAD,
    PH_OPEN,
    PH_DATA,
    PH_DATA_X,
    PH_CRCH,
    PH_CRCH_X,
    PH_CRCL,
    PH_CRCL_X,
    PH_CLOSE
  } phase_e;

  // CRC-16/CCITT, polynomial 0x1021, one byte MSB first.
  function automatic logic [15:0] crc_update(logic [15:0] crc, logic [7:0] b);
    logic [7:0] x;
    x = crc[15:8] ^ b;
    x = x ^ {4'b0000, x[7:4]};
    return {crc[7:0], 8'h00} ^ {x[3:0], 12'h000} ^ {3'b000, x, 5'b00000}
           ^ {8'h00, x};
  endfunction

  function automatic logic needs_escape(logic [7:0] b);
    return (b == FlagOctet) || (b == EscOctet);
  endfunction

endpackage

// ----- hw/rtl/bsft_front.sv -----
module bsft_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  bsft_pkg::in_req_t in_data_i,
  output logic              push_o,
  output bsft_pkg::job_t    push_job_o,
  input  logic              full_i
);

  logic        inside_q, inside_d;
  logic [15:0] crc_q, crc_d;
  logic [15:0] crc_base, crc_new;

  assign in_ready_o = !full_i;
  assign push_o     = in_valid_i && !full_i;

  // A closed frame restarts the CRC on its first byte.
  assign crc_base = inside_q ? crc_q : bsft_pkg::CrcStart;
  assign crc_new  = bsft_pkg::crc_update(crc_base, in_data_i.data_byte);

  always_comb begin
    push_job_o.data_byte  = in_data_i.data_byte;
    push_job_o.last_byte  = in_data_i.last_byte;
    push_job_o.open_frame = !inside_q;
    push_job_o.crc        = crc_new;
    inside_d = inside_q;
    crc_d    = crc_q;
    if (push_o) begin
      inside_d = !in_data_i.last_byte;
      crc_d    = in_data_i.last_byte ? bsft_pkg::CrcStart : crc_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inside_q <= 1'b0;
      crc_q    <= bsft_pkg::CrcStart;
    end else begin
      inside_q <= inside_d;
      crc_q    <= crc_d;
    end
  end

endmodule

// ----- hw/rtl/bsft_queue.sv -----
module bsft_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  bsft_pkg::job_t push_job_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           empty_o,
  output bsft_pkg::job_t head_o
);

  bsft_pkg::job_t                  entries_q [bsft_pkg::QDepth];
  logic [bsft_pkg::QPtrW-1:0]      wr_ptr_q, rd_ptr_q;
  logic [bsft_pkg::QCntW-1:0]      count_q;

  assign full_o  = (count_q == bsft_pkg::QCntW'(bsft_pkg::QDepth));
  assign empty_o = (count_q == '0);
  assign head_o  = entries_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entries_q[wr_ptr_q] <= push_job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + bsft_pkg::QPtrW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + bsft_pkg::QPtrW'(1);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + bsft_pkg::QCntW'(1);
      end else if (pop_i && !push_i) begin
        count_q <= count_q - bsft_pkg::QCntW'(1);
      end
    end
  end

endmodule

// ----- hw/rtl/bsft_back.sv -----
module bsft_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               empty_i,
  input  bsft_pkg::job_t     head_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output bsft_pkg::out_req_t out_data_o
);

  bsft_pkg::phase_e   state_q, state_d, phase;
  bsft_pkg::out_req_t out_q, octet;
  logic               out_valid_q;
  logic               load;
  logic               done;

  assign load = !empty_i && (!out_valid_q || out_ready_i);
  assign pop_o = load && done;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // A fresh queue head starts with its opening flag or straight with data.
  always_comb begin
    if (state_q == bsft_pkg::PH_HEAD) begin
      phase = head_i.open_frame ? bsft_pkg::PH_OPEN : bsft_pkg::PH_DATA;
    end else begin
      phase = state_q;
    end
  end

  always_comb begin
    octet.line_byte = bsft_pkg::FlagOctet;
    octet.frame_end = 1'b0;
    done            = 1'b0;
    state_d         = state_q;
    unique case (phase)
      bsft_pkg::PH_HEAD, bsft_pkg::PH_OPEN: begin
        state_d = bsft_pkg::PH_DATA;
      end
      bsft_pkg::PH_DATA: begin
        if (bsft_pkg::needs_escape(head_i.data_byte)) begin
          octet.line_byte = bsft_pkg::EscOctet;
          state_d         = bsft_pkg::PH_DATA_X;
        end else begin
          octet.line_byte = head_i.data_byte;
          done            = !head_i.last_byte;
          state_d         = head_i.last_byte ? bsft_pkg::PH_CRCH : bsft_pkg::PH_HEAD;
        end
      end
      bsft_pkg::PH_DATA_X: begin
        octet.line_byte = head_i.data_byte ^ bsft_pkg::EscFlip;
        done            = !head_i.last_byte;
        state_d         = head_i.last_byte ? bsft_pkg::PH_CRCH : bsft_pkg::PH_HEAD;
      end
      bsft_pkg::PH_CRCH: begin
        if (bsft_pkg::needs_escape(head_i.crc[15:8])) begin
          octet.line_byte = bsft_pkg::EscOctet;
          state_d         = bsft_pkg::PH_CRCH_X;
        end else begin
          octet.line_byte = head_i.crc[15:8];
          state_d         = bsft_pkg::PH_CRCL;
        end
      end
      bsft_pkg::PH_CRCH_X: begin
        octet.line_byte = head_i.crc[15:8] ^ bsft_pkg::EscFlip;
        state_d         = bsft_pkg::PH_CRCL;
      end
      bsft_pkg::PH_CRCL: begin
        if (bsft_pkg::needs_escape(head_i.crc[7:0])) begin
          octet.line_byte = bsft_pkg::EscOctet;
          state_d         = bsft_pkg::PH_CRCL_X;
        end else begin
          octet.line_byte = head_i.crc[7:0];
          state_d         = bsft_pkg::PH_CLOSE;
        end
      end
      bsft_pkg::PH_CRCL_X: begin
        octet.line_byte = head_i.crc[7:0] ^ bsft_pkg::EscFlip;
        state_d         = bsft_pkg::PH_CLOSE;
      end
      bsft_pkg::PH_CLOSE: begin
        octet.frame_end = 1'b1;
        done            = 1'b1;
        state_d         = bsft_pkg::PH_HEAD;
      end
      default: begin
        state_d = bsft_pkg::PH_HEAD;
      end
    endcase
    octet.run_last = done;
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_q <= octet;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= bsft_pkg::PH_HEAD;
      out_valid_q <= 1'b0;
    end else begin
      if (load) begin
        state_q     <= state_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

endmodule

// ----- hw/rtl/byte_stuffed_frame_transmitter_unit.sv -----
// A request's first line octet passes through the job queue and then the back's output register.
// Throughput: one line octet per cycle while out_ready_i is high; a request expands to 1 to 8
//   octets (escapes, flags, CRC), which the back sequencer emits one a cycle.
// Front accepts a request each cycle while the 2-entry job queue has room.
// Reset (rst_ni, async, active low): no frame open, CRC at 0xFFFF, queue and output empty.
module byte_stuffed_frame_transmitter_unit (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  bsft_pkg::in_req_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output bsft_pkg::out_req_t out_data_o
);

  // Front to queue
  logic           push;
  bsft_pkg::job_t push_job;
  logic           full;

  // Queue to back
  logic           pop;
  logic           empty;
  bsft_pkg::job_t head;

  // Front: tracks frame state, runs the CRC over payload and tags each byte
  // with whether it opens a frame, plus the CRC after it.
  bsft_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .push_o     (push),
    .push_job_o (push_job),
    .full_i     (full)
  );

  // Short job queue decouples request intake from line pacing.
  bsft_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_job_i (push_job),
    .full_o     (full),
    .pop_i      (pop),
    .empty_o    (empty),
    .head_o     (head)
  );

  // Back: walks each job through opening flag (frame start only), escaped data, and at frame end
  // escaped CRC bytes and closing flag, one octet per cycle into the output register unless out_ready_i stalls it.
  bsft_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (empty),
    .head_i      (head),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

// ----- tb/sv/tb.sv -----
`timescale 1ns / 1ps

module tb;

  localparam logic [15:0] CcittPoly  = 16'h1021;
  localparam int          CycleLimit = 200000;
  localparam int          CalmFrom   = 600;   // no idling on either side in this window
  localparam int          CalmTo     = 1000;
  localparam int          DrainWait  = 20;    // cycles allowed past the last expected octet
  localparam int          RandTarget = 450;

  logic               clk_i       = 1'b0;
  logic               rst_ni      = 1'b0;
  logic               in_valid_i  = 1'b0;
  logic               in_ready_o;
  bsft_pkg::in_req_t  in_data_i   = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  bsft_pkg::out_req_t out_data_o;

  byte_stuffed_frame_transmitter_unit uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Payload requests waiting for the driver, and line octets still owed by the block.
  bsft_pkg::in_req_t  payload_queue[$];
  bsft_pkg::out_req_t octets_due[$];
  bsft_pkg::out_req_t octet_burst[$];

  // Framer shadow state.
  logic        frame_open = 1'b0;
  logic [15:0] frame_crc  = bsft_pkg::CrcStart;

  int cycle_count    = 0;
  int mismatches     = 0;
  int bytes_accepted = 0;
  int octets_checked = 0;
  int frames_closed  = 0;
  int escapes_seen   = 0;
  int longest_burst  = 0;

  // Bitwise CRC-16/CCITT, MSB first.
  function automatic logic [15:0] ccitt_next(logic [15:0] crc, logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++)
      c = c[15] ? ({c[14:0], 1'b0} ^ CcittPoly) : {c[14:0], 1'b0};
    return c;
  endfunction

  function automatic bit take_a_break();
    if (cycle_count >= CalmFrom && cycle_count < CalmTo) return 1'b0;
    return $urandom_range(99) < 24;
  endfunction

  task automatic push_octet(input logic [7:0] b, input logic fe);
    octet_burst.push_back(bsft_pkg::out_req_t'{line_byte: b, run_last: 1'b0, frame_end: fe});
  endtask

  task automatic push_stuffed(input logic [7:0] b);
    if (b == bsft_pkg::FlagOctet || b == bsft_pkg::EscOctet) begin
      push_octet(bsft_pkg::EscOctet, 1'b0);
      push_octet(b ^ bsft_pkg::EscFlip, 1'b0);
    end else begin
      push_octet(b, 1'b0);
    end
  endtask

  // Expands one accepted payload request into the octets it owes on the line.
  task automatic expand_request(input bsft_pkg::in_req_t r);
    bsft_pkg::out_req_t tail_octet;
    if (!frame_open) begin
      push_octet(bsft_pkg::FlagOctet, 1'b0);
      frame_open = 1'b1;
      frame_crc  = bsft_pkg::CrcStart;
    end
    push_stuffed(r.data_byte);
    frame_crc = ccitt_next(frame_crc, r.data_byte);
    if (r.last_byte) begin
      push_stuffed(frame_crc[15:8]);
      push_stuffed(frame_crc[7:0]);
      push_octet(bsft_pkg::FlagOctet, 1'b1);
      frame_open = 1'b0;
      frame_crc  = bsft_pkg::CrcStart;
    end
    tail_octet = octet_burst.pop_back();
    tail_octet.run_last = 1'b1;
    octet_burst.push_back(tail_octet);
    if (octet_burst.size() > longest_burst) longest_burst = octet_burst.size();
    foreach (octet_burst[k]) octets_due.push_back(octet_burst[k]);
    octet_burst.delete();
  endtask

  task automatic add_request(input logic [7:0] b, input logic last);
    payload_queue.push_back(bsft_pkg::in_req_t'{data_byte: b, last_byte: last});
  endtask

  // Two-byte frame whose CRC high (or low) byte must be escaped on the line.
  function automatic logic [15:0] find_escaping_crc_pair(bit high_half);
    logic [15:0] c;
    logic [7:0]  part;
    for (int a = 0; a < 256; a++) begin
      for (int b = 0; b < 256; b++) begin
        c    = ccitt_next(ccitt_next(bsft_pkg::CrcStart, 8'(a)), 8'(b));
        part = high_half ? c[15:8] : c[7:0];
        if (part == bsft_pkg::FlagOctet || part == bsft_pkg::EscOctet) return {8'(a), 8'(b)};
      end
    end
    return 16'h0000;
  endfunction

  // Run watchdog.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  // Request driver: valid held with stable payload until accepted.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        expand_request(in_data_i);
        bytes_accepted++;
      end
      if (!in_valid_i || in_ready_o) begin
        if (payload_queue.size() != 0 && !take_a_break()) begin
          in_data_i  <= payload_queue.pop_front();
          in_valid_i <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Line monitor: random back-pressure, each octet checked against the oldest owed one.
  always @(posedge clk_i) begin
    bsft_pkg::out_req_t want;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        octets_checked++;
        if (out_data_o.line_byte == bsft_pkg::EscOctet) escapes_seen++;
        if (out_data_o.frame_end) frames_closed++;
        if (octets_due.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("octet %0d: unexpected %h (last %b end %b), nothing owed",
                     octets_checked, out_data_o.line_byte, out_data_o.run_last,
                     out_data_o.frame_end);
        end else begin
          want = octets_due.pop_front();
          if (out_data_o.line_byte != want.line_byte || out_data_o.run_last != want.run_last ||
              out_data_o.frame_end != want.frame_end) begin
            mismatches++;
            if (mismatches <= 10)
              $display("octet %0d: expected %h/%b/%b, got %h/%b/%b (byte/last/end)",
                       octets_checked, want.line_byte, want.run_last, want.frame_end,
                       out_data_o.line_byte, out_data_o.run_last, out_data_o.frame_end);
          end
        end
      end
      out_ready_i <= !take_a_break();
    end
  end

  initial begin
    logic [15:0] pair;
    int          issued;
    int          frame_len;
    logic [7:0]  b;

    // Directed frames: extremes, escapes, look-alikes of escaped bytes, escaped CRC.
    add_request(8'h00, 1'b1);
    add_request(8'hFF, 1'b1);
    add_request(bsft_pkg::FlagOctet, 1'b0);
    add_request(bsft_pkg::EscOctet, 1'b0);
    add_request(8'h5E, 1'b0);
    add_request(8'h5D, 1'b0);
    add_request(8'hFF, 1'b1);
    add_request(bsft_pkg::FlagOctet, 1'b1);
    add_request(bsft_pkg::EscOctet, 1'b1);
    pair = find_escaping_crc_pair(1'b1);
    add_request(pair[15:8], 1'b0);
    add_request(pair[7:0], 1'b1);
    pair = find_escaping_crc_pair(1'b0);
    add_request(pair[15:8], 1'b0);
    add_request(pair[7:0], 1'b1);
    add_request(8'h55, 1'b0);
    add_request(8'hAA, 1'b0);
    add_request(8'h01, 1'b0);
    add_request(8'h80, 1'b1);

    // Random frames, mostly short, some long, escape bytes favoured.
    issued = 0;
    while (issued < RandTarget) begin
      case ($urandom_range(19))
        0:       frame_len = 1;
        1, 2, 3: frame_len = $urandom_range(20, 7);
        default: frame_len = $urandom_range(6, 1);
      endcase
      for (int i = 0; i < frame_len; i++) begin
        if ($urandom_range(99) < 20) b = $urandom_range(1) ? bsft_pkg::EscOctet : bsft_pkg::FlagOctet;
        else b = 8'($urandom_range(255));
        add_request(b, i == frame_len - 1);
        issued++;
      end
    end

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (payload_queue.size() != 0 || in_valid_i || octets_due.size() != 0)
      @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);

    if (octets_due.size() != 0) begin
      mismatches += octets_due.size();
      $display("%0d line octets never arrived", octets_due.size());
    end

    $display("Sent %0d payload bytes in %0d closed frames; %0d line octets checked.",
             bytes_accepted, frames_closed, octets_checked);
    $display("Escape octets seen: %0d; longest expansion of one byte: %0d octets.",
             escapes_seen, longest_burst);
    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
